>>> rtl/efia_pkg.sv
package efia_pkg;

	// field widths
	localparam int DOSE_W   = 24;
	localparam int WEIGHT_W = 17;
	localparam int CFG_W    = 24;
	localparam int GRAD_W   = 32;
	localparam int G1_W     = 17;
	localparam int ACC_W    = 64;
	localparam int NUM_ACC  = 6;

	// serial divider widths
	localparam int DIV_W    = 50;
	localparam int DIVLO_W  = 32;
	localparam int STEP_W   = 6;

	// stream widths
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = NUM_ACC * ACC_W;

	// register indexes
	localparam logic REG_SLOPE = 1'b0;
	localparam logic REG_HALF  = 1'b1;

	// register reset values
	localparam logic [CFG_W-1:0] SLOPE_RESET = 24'd65536;
	localparam logic [CFG_W-1:0] HALF_RESET  = 24'd65536;

	// constant gradient term, 1.0 in q16.16
	localparam logic [GRAD_W-1:0] ONE_Q16 = 32'd65536;

	// division steps for the two quotients
	localparam logic [STEP_W-1:0] STEPS_RATIO = 6'd17;
	localparam logic [STEP_W-1:0] STEPS_SLOPE = 6'd32;

	// request to the serial divider
	typedef struct packed {
		logic               start;
		logic [DIV_W-1:0]   rem_init;
		logic [DIVLO_W-1:0] low;
		logic [DIV_W-1:0]   divisor;
		logic [STEP_W-1:0]  steps;
	} div_req_t;

	// gradient of one design point
	typedef struct packed {
		logic [G1_W-1:0]          g1;
		logic signed [GRAD_W-1:0] g2;
		logic                     sat;
	} grad_res_t;

endpackage

>>> rtl/efia_serial_div.sv
module efia_serial_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  efia_pkg::div_req_t               req,
	output logic                             done,
	output logic [efia_pkg::DIVLO_W-1:0]     quo
);

	logic [efia_pkg::DIV_W-1:0]   rem_q;
	logic [efia_pkg::DIV_W-1:0]   div_q;
	logic [efia_pkg::DIVLO_W-1:0] low_q;
	logic [efia_pkg::DIVLO_W-1:0] quo_q;
	logic [efia_pkg::STEP_W-1:0]  cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [efia_pkg::DIV_W+1:0]   diff;
	logic                         ge;

	// trial subtract of the shifted remainder
	always_comb begin
		diff = {1'b0, rem_q, low_q[efia_pkg::DIVLO_W-1]} - {2'b00, div_q};
		ge   = ~diff[efia_pkg::DIV_W+1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			low_q <= req.low;
			div_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[efia_pkg::DIV_W-1:0]
			            : {rem_q[efia_pkg::DIV_W-2:0], low_q[efia_pkg::DIVLO_W-1]};
			low_q <= {low_q[efia_pkg::DIVLO_W-2:0], 1'b0};
			quo_q <= {quo_q[efia_pkg::DIVLO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/efia_grad.sv
module efia_grad (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [efia_pkg::DOSE_W-1:0]    dose,
	input  logic [efia_pkg::CFG_W-1:0]     slope,
	input  logic [efia_pkg::CFG_W-1:0]     half,
	output logic                           done,
	output efia_pkg::grad_res_t            res
);

	localparam logic [1:0] G_IDLE = 2'd0;
	localparam logic [1:0] G_MUL  = 2'd1;
	localparam logic [1:0] G_DIV1 = 2'd2;
	localparam logic [1:0] G_DIV2 = 2'd3;

	logic [1:0]                     state_q;
	logic [efia_pkg::DOSE_W-1:0]    x_q;
	logic [efia_pkg::DOSE_W:0]      c_q;
	logic [2*efia_pkg::DOSE_W-1:0]  sx_q;
	logic [efia_pkg::DIV_W-1:0]     cc_q;
	logic                           sneg_q;
	logic                           done_q;
	efia_pkg::grad_res_t            res_q;

	logic [efia_pkg::CFG_W-1:0]     s_mag;
	logic                           big;
	efia_pkg::div_req_t             dreq;
	logic                           div_done;
	logic [efia_pkg::DIVLO_W-1:0]   quo;
	logic [efia_pkg::GRAD_W:0]      g2_sat;

	// slope term from the quotient magnitude, saturated to q16.16
	function automatic logic [efia_pkg::GRAD_W:0] slope_term(
		input logic                         ovr,
		input logic [efia_pkg::GRAD_W-1:0]  mag,
		input logic                         neg
	);
		logic [efia_pkg::GRAD_W:0] r;
		if (neg) begin
			if (ovr || mag[efia_pkg::GRAD_W-1]) r = {1'b1, 32'h7FFF_FFFF};
			else r = {1'b0, mag};
		end else begin
			if (ovr || (mag > 32'h8000_0000)) r = {1'b1, 32'h8000_0000};
			else r = {1'b0, 32'(-mag)};
		end
		return r;
	endfunction

	assign s_mag  = slope[efia_pkg::CFG_W-1] ? 24'(-slope) : slope;
	// quotient reaches 2^32 when the upper half of the numerator covers the divisor
	assign big    = {18'd0, sx_q[2*efia_pkg::DOSE_W-1:16]} >= cc_q;
	assign g2_sat = slope_term(big, quo, sneg_q);

	// divider requests: ratio first, then slope term
	always_comb begin
		dreq = '0;
		unique case (state_q)
			G_MUL: begin
				dreq.start    = (c_q != '0);
				dreq.rem_init = 50'(x_q[efia_pkg::DOSE_W-1:1]);
				dreq.low      = {x_q[0], 31'd0};
				dreq.divisor  = 50'(c_q);
				dreq.steps    = efia_pkg::STEPS_RATIO;
			end
			G_DIV1: begin
				dreq.start    = div_done && !big;
				dreq.rem_init = 50'(sx_q[2*efia_pkg::DOSE_W-1:16]);
				dreq.low      = {sx_q[15:0], 16'd0};
				dreq.divisor  = cc_q;
				dreq.steps    = efia_pkg::STEPS_SLOPE;
			end
			default: dreq = '0;
		endcase
	end

	efia_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (div_done),
		.quo    (quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				G_IDLE: if (start) state_q <= G_MUL;
				G_MUL: begin
					if (c_q == '0) begin
						done_q  <= 1'b1;
						state_q <= G_IDLE;
					end else begin
						state_q <= G_DIV1;
					end
				end
				G_DIV1: begin
					if (div_done) begin
						if (big) begin
							done_q  <= 1'b1;
							state_q <= G_IDLE;
						end else begin
							state_q <= G_DIV2;
						end
					end
				end
				G_DIV2: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= G_IDLE;
					end
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	// operands and results
	always_ff @(posedge clk) begin
		if (state_q == G_IDLE && start) begin
			x_q    <= dose;
			c_q    <= {1'b0, dose} + {1'b0, half};
			sx_q   <= 48'(s_mag) * 48'(dose);
			sneg_q <= slope[efia_pkg::CFG_W-1];
		end
		if (state_q == G_MUL) begin
			cc_q <= 50'(c_q) * 50'(c_q);
			if (c_q == '0) res_q <= '0;
		end
		if (state_q == G_DIV1 && div_done) begin
			res_q.g1 <= quo[efia_pkg::G1_W-1:0];
			if (big) begin
				res_q.g2  <= g2_sat[efia_pkg::GRAD_W-1:0];
				res_q.sat <= g2_sat[efia_pkg::GRAD_W];
			end
		end
		if (state_q == G_DIV2 && div_done) begin
			res_q.g2  <= g2_sat[efia_pkg::GRAD_W-1:0];
			res_q.sat <= g2_sat[efia_pkg::GRAD_W];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

>>> rtl/efia_accum.sv
module efia_accum (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              start,
	input  logic                                              clear,
	input  efia_pkg::grad_res_t                               grad,
	input  logic [efia_pkg::WEIGHT_W-1:0]                     weight,
	output logic                                              done,
	output logic [efia_pkg::NUM_ACC-1:0][efia_pkg::ACC_W-1:0] acc,
	output logic                                              ovf
);

	localparam logic [2:0] LAST_TERM = 3'd5;
	localparam logic [2:0] PH_MUL    = 3'd0;
	localparam logic [2:0] PH_LO     = 3'd1;
	localparam logic [2:0] PH_HI     = 3'd2;
	localparam logic [2:0] PH_TERM   = 3'd3;
	localparam logic [2:0] PH_ADD    = 3'd4;

	logic [efia_pkg::G1_W-1:0]                         g1_q;
	logic [efia_pkg::GRAD_W-1:0]                       g2_q;
	logic [efia_pkg::WEIGHT_W-1:0]                     w_q;
	logic [2:0]                                        k_q;
	logic [2:0]                                        ph_q;
	logic                                              busy_q;
	logic                                              done_q;
	logic                                              ovf_q;
	logic [63:0]                                       m1_q;
	logic                                              neg_q;
	logic [48:0]                                       plo_q;
	logic [48:0]                                       phi_q;
	logic [efia_pkg::ACC_W-1:0]                        term_q;
	logic [efia_pkg::NUM_ACC-1:0][efia_pkg::ACC_W-1:0] acc_q;

	logic [1:0]                  sel_a, sel_b;
	logic [efia_pkg::GRAD_W-1:0] g2_mag;
	logic [efia_pkg::GRAD_W-1:0] mag_a, mag_b;
	logic                        sgn_a, sgn_b;
	logic [63:0]                 m1_d;
	logic [80:0]                 sum;
	logic [62:0]                 r;
	logic [efia_pkg::ACC_W-1:0]  acc_cur, acc_sum;
	logic                        acc_ovr;
	logic [efia_pkg::ACC_W-1:0]  acc_new;

	// gradient magnitude by index
	function automatic logic [efia_pkg::GRAD_W-1:0] gmag(
		input logic [1:0]                  sel,
		input logic [efia_pkg::G1_W-1:0]   g1,
		input logic [efia_pkg::GRAD_W-1:0] g2m
	);
		logic [efia_pkg::GRAD_W-1:0] m;
		case (sel)
			2'd1:    m = 32'(g1);
			2'd2:    m = g2m;
			default: m = efia_pkg::ONE_Q16;
		endcase
		return m;
	endfunction

	// upper triangle index pairs
	always_comb begin
		case (k_q)
			3'd1:    begin sel_a = 2'd0; sel_b = 2'd1; end
			3'd2:    begin sel_a = 2'd0; sel_b = 2'd2; end
			3'd3:    begin sel_a = 2'd1; sel_b = 2'd1; end
			3'd4:    begin sel_a = 2'd1; sel_b = 2'd2; end
			3'd5:    begin sel_a = 2'd2; sel_b = 2'd2; end
			default: begin sel_a = 2'd0; sel_b = 2'd0; end
		endcase
	end

	assign g2_mag = g2_q[efia_pkg::GRAD_W-1] ? 32'(-g2_q) : g2_q;
	assign mag_a  = gmag(sel_a, g1_q, g2_mag);
	assign mag_b  = gmag(sel_b, g1_q, g2_mag);
	assign sgn_a  = (sel_a == 2'd2) && g2_q[efia_pkg::GRAD_W-1];
	assign sgn_b  = (sel_b == 2'd2) && g2_q[efia_pkg::GRAD_W-1];
	assign m1_d   = 64'(mag_a) * 64'(mag_b);

	// weighted product recombined from two 32-bit digits, dropping 16 fraction bits
	assign sum = {phi_q, 32'd0} + {32'd0, plo_q};
	assign r   = sum[78:16];

	// saturating accumulate
	always_comb begin
		acc_cur = acc_q[k_q];
		acc_sum = acc_cur + term_q;
		acc_ovr = (acc_cur[63] == term_q[63]) && (acc_sum[63] != acc_cur[63]);
		if (acc_ovr) acc_new = acc_cur[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else acc_new = acc_sum;
	end

	// sequencer over six terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
			ph_q   <= PH_MUL;
			ovf_q  <= 1'b0;
			acc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (clear) begin
				acc_q <= '0;
				ovf_q <= 1'b0;
			end else if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
				ph_q   <= PH_MUL;
				ovf_q  <= ovf_q | grad.sat;
			end else if (busy_q) begin
				if (ph_q == PH_ADD) begin
					acc_q[k_q] <= acc_new;
					ovf_q      <= ovf_q | acc_ovr;
					ph_q       <= PH_MUL;
					if (k_q == LAST_TERM) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end else begin
					ph_q <= ph_q + 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			g1_q <= grad.g1;
			g2_q <= grad.g2;
			w_q  <= weight;
		end else if (busy_q) begin
			case (ph_q)
				PH_MUL: begin
					m1_q  <= m1_d;
					neg_q <= sgn_a ^ sgn_b;
				end
				PH_LO:   plo_q  <= 49'(m1_q[31:0]) * 49'(w_q);
				PH_HI:   phi_q  <= 49'(m1_q[63:32]) * 49'(w_q);
				PH_TERM: term_q <= neg_q ? 64'(-{1'b0, r}) : {1'b0, r};
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign acc  = acc_q;
	assign ovf  = ovf_q;

endmodule

>>> rtl/emax_fisher_info_accumulator_top.sv
// Fisher information accumulator for the three-parameter Emax model.
// Input stream: one design point per transaction. s_axis_tdata carries the
// dose (unsigned q8.16) and the weight (unsigned q1.16); s_axis_tlast marks
// the last point of a set. Output stream: one transaction per set, the six
// upper-triangle entries (signed q32.32) on m_axis_tdata and the overflow flag
// on m_axis_tuser. Slope and half point are written on the cfg port; the user
// is to write them only while idle, the block itself does not enforce this.
// Points are processed one at a time: the ratio and the slope term quotient
// on the shared one-bit-per-cycle divider, then the six weighted products
// through the 32x17 product datapath, with handoff between the stages. When
// the slope term quotient is known to saturate the second division is
// skipped; when dose and half point are both zero both divisions are skipped.
// A closing point also passes through the emit state: its result is loaded
// into the output register, and the next point is accepted only after that.
// Reset clears the accumulators, the overflow flag and the output valid flag
// and loads both registers with 1.0. A stalled receiver holds the result in
// the output register; the next set is accepted meanwhile, and the block
// only waits when a further set closes before the held result is taken.
module emax_fisher_info_accumulator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// dose [23:0], weight [40:24], zero fill [47:41]
	input  logic [efia_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic                                s_axis_tlast,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// m00 [63:0], m01 [127:64], m02 [191:128], m11 [255:192], m12 [319:256],
	// m22 [383:320]
	output logic [efia_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// overflow [0]
	output logic                                m_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [efia_pkg::CFG_W-1:0]          cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GRAD = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                               state_q;
	logic [efia_pkg::CFG_W-1:0]               slope_q;
	logic [efia_pkg::CFG_W-1:0]               half_q;
	logic [efia_pkg::WEIGHT_W-1:0]            w_q;
	logic                                     last_q;
	logic                                     out_valid_q;
	logic [efia_pkg::OUT_TDATA_W-1:0]         out_data_q;
	logic                                     out_ovf_q;

	logic                                     in_fire;
	logic                                     grad_done;
	efia_pkg::grad_res_t                      grad_res;
	logic                                     acc_done;
	logic [efia_pkg::NUM_ACC-1:0][efia_pkg::ACC_W-1:0] acc;
	logic                                     acc_ovf;
	logic                                     load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign load          = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_q <= efia_pkg::SLOPE_RESET;
			half_q  <= efia_pkg::HALF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				efia_pkg::REG_SLOPE: slope_q <= cfg_data;
				efia_pkg::REG_HALF:  half_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// gradient of the point
	efia_grad u_grad (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire),
		.dose   (s_axis_tdata[efia_pkg::DOSE_W-1:0]),
		.slope  (slope_q),
		.half   (half_q),
		.done   (grad_done),
		.res    (grad_res)
	);

	// weighted outer product into the accumulators
	efia_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (grad_done),
		.clear  (load),
		.grad   (grad_res),
		.weight (w_q),
		.done   (acc_done),
		.acc    (acc),
		.ovf    (acc_ovf)
	);

	// point sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_fire) state_q <= ST_GRAD;
				ST_GRAD: if (grad_done) state_q <= ST_ACC;
				ST_ACC:  if (acc_done) state_q <= last_q ? ST_EMIT : ST_IDLE;
				ST_EMIT: if (load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// point payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			w_q    <= s_axis_tdata[efia_pkg::DOSE_W +: efia_pkg::WEIGHT_W];
			last_q <= s_axis_tlast;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= acc;
			out_ovf_q  <= acc_ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ovf_q;

endmodule

>>> tb/sv/emax_fisher_info_accumulator_top_tb.sv
`timescale 1ns / 100ps

module emax_fisher_info_accumulator_top_tb;
	import efia_pkg::*;

	localparam int PAD_W      = IN_TDATA_W - DOSE_W - WEIGHT_W;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYC = 200;
	localparam int HOLD_CYC   = 800;
	localparam int PHASES     = 8;
	localparam int PHASE_PTS  = 123;

	// one set result: six matrix entries and the overflow flag
	typedef struct packed {
		logic [NUM_ACC-1:0][ACC_W-1:0] entry;
		logic                          ovf;
	} fisher_t;

	// one row of the directed table: a register write or a design point
	typedef struct {
		bit                  is_cfg;
		logic                sel;
		logic [CFG_W-1:0]    value;
		logic [WEIGHT_W-1:0] wt;
		bit                  closes;
		bit                  typed;
		fisher_t             want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic                   cfg_we = 1'b0;
	logic                   cfg_index = REG_SLOPE;
	logic [CFG_W-1:0]       cfg_data = '0;

	// predictor state
	logic [CFG_W-1:0]   slope_q = SLOPE_RESET;
	logic [CFG_W-1:0]   half_q = HALF_RESET;
	logic signed [63:0] info_acc [NUM_ACC] = '{default: '0};
	bit                 info_sat = 1'b0;

	fisher_t   fisher_due [$];
	stim_row_t stim_rows [$];

	int  fail_count = 0;
	int  point_count = 0;
	int  set_count = 0;
	int  sat_sets = 0;
	int  setting_count = 0;
	bit  send_calm = 1'b0;
	bit  block_busy = 1'b0;

	string       entry_name [NUM_ACC] = '{"m00", "m01", "m02", "m11", "m12", "m22"};
	logic [23:0] slope_corner [4] = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
	logic [23:0] half_corner [4] = '{24'h000001, 24'hFFFFFF, 24'h000000, 24'h010000};

	emax_fisher_info_accumulator_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// signed 64-bit add, clamps and flags on overflow
	function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			info_sat = 1'b1;
			return a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end
		return s;
	endfunction

	// w * ga * gb scaled down by 2^16, truncated toward zero
	function automatic logic signed [63:0] scaled_term(input logic [WEIGHT_W-1:0] wt,
			input logic signed [63:0] ga, input logic signed [63:0] gb);
		logic signed [63:0] p;
		logic [63:0]        mag;
		logic [63:0]        r;
		p = ga * gb;
		mag = p[63] ? 64'(-p) : 64'(p);
		r = (mag >> 16) * 64'(wt) + (((mag & 64'hFFFF) * 64'(wt)) >> 16);
		return p[63] ? -$signed(r) : $signed(r);
	endfunction

	// gradient of one point, accumulate, and close the set when marked
	function automatic bit fisher_step(input logic [DOSE_W-1:0] dose,
			input logic [WEIGHT_W-1:0] wt, input bit closes, output fisher_t res);
		logic [63:0]        x;
		logic [63:0]        c;
		logic [63:0]        s_mag;
		logic [63:0]        quo;
		logic signed [63:0] grad [3];
		bit                 s_neg;
		int                 ia [NUM_ACC];
		int                 ib [NUM_ACC];
		ia = '{0, 0, 0, 1, 1, 2};
		ib = '{0, 1, 2, 1, 2, 2};
		res = '0;
		x = 64'(dose);
		c = x + 64'(half_q);
		s_neg = slope_q[CFG_W-1];
		s_mag = s_neg ? 64'h100_0000 - 64'(slope_q) : 64'(slope_q);
		grad[0] = 64'(ONE_Q16);
		grad[1] = '0;
		grad[2] = '0;
		// zero divisor leaves both dose terms at zero
		if (c != 0) begin
			grad[1] = (x << 16) / c;
			quo = ((s_mag * x) << 16) / (c * c);
			if (!s_neg) begin
				if (quo > 64'd2147483648) begin
					grad[2] = -64'sd2147483648;
					info_sat = 1'b1;
				end else begin
					grad[2] = -$signed(quo);
				end
			end else if (quo > 64'd2147483647) begin
				grad[2] = 64'sd2147483647;
				info_sat = 1'b1;
			end else begin
				grad[2] = $signed(quo);
			end
		end
		for (int k = 0; k < NUM_ACC; k++)
			info_acc[k] = sat_sum(info_acc[k], scaled_term(wt, grad[ia[k]], grad[ib[k]]));
		if (!closes)
			return 1'b0;
		for (int k = 0; k < NUM_ACC; k++) begin
			res.entry[k] = info_acc[k];
			info_acc[k] = '0;
		end
		res.ovf = info_sat;
		info_sat = 1'b0;
		return 1'b1;
	endfunction

	function automatic void row_cfg(input logic sel, input logic [CFG_W-1:0] value);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.sel = sel;
		r.value = value;
		stim_rows.push_back(r);
	endfunction

	function automatic void row_point(input logic [DOSE_W-1:0] dose,
			input logic [WEIGHT_W-1:0] wt, input bit closes);
		stim_row_t r;
		r = '{default: '0};
		r.value = dose;
		r.wt = wt;
		r.closes = closes;
		stim_rows.push_back(r);
	endfunction

	// closing point whose result is written out by hand
	function automatic void row_typed(input logic [DOSE_W-1:0] dose,
			input logic [WEIGHT_W-1:0] wt, input logic [63:0] m00, input logic [63:0] m01,
			input logic [63:0] m02, input logic [63:0] m11, input logic [63:0] m12,
			input logic [63:0] m22, input logic ovf);
		stim_row_t r;
		r = '{default: '0};
		r.value = dose;
		r.wt = wt;
		r.closes = 1'b1;
		r.typed = 1'b1;
		r.want.entry = {m22, m12, m11, m02, m01, m00};
		r.want.ovf = ovf;
		stim_rows.push_back(r);
	endfunction

	// offer one design point and, if it closes a set, queue the set's expected result on acceptance
	task automatic offer_point(input logic [DOSE_W-1:0] dose, input logic [WEIGHT_W-1:0] wt,
			input bit closes, input bit typed, input fisher_t want);
		int      gap;
		fisher_t pred;
		gap = send_calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {{PAD_W{1'b0}}, wt, dose};
		s_axis_tlast <= closes;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		block_busy = 1'b1;
		point_count++;
		if (fisher_step(dose, wt, closes, pred)) begin
			set_count++;
			if (pred.ovf)
				sat_sets++;
			fisher_due.push_back(typed ? want : pred);
		end
	endtask

	// stop offering, let every result drain and the block go quiet
	task automatic settle_idle();
		if (block_busy) begin
			s_axis_tvalid <= 1'b0;
			while (fisher_due.size() != 0)
				@(posedge clk);
			repeat (SETTLE_CYC) @(posedge clk);
			block_busy = 1'b0;
		end
	endtask

	task automatic write_setting(input logic sel, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		@(posedge clk);
		if (sel == REG_SLOPE)
			slope_q = value;
		else
			half_q = value;
		setting_count++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [DOSE_W-1:0] pick_dose();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return DOSE_W'($urandom_range(0, 1023));
			4, 5:    return half_q ^ DOSE_W'($urandom_range(0, 255));
			default: return DOSE_W'($urandom);
		endcase
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 17'h10000;
			2:       return WEIGHT_W'($urandom_range(0, 131071));
			3:       return '1;
			default: return WEIGHT_W'($urandom_range(0, 65536));
		endcase
	endfunction

	// result sink: random stalls, calm stretches, two long hold-offs
	initial begin : result_sink
		int stall;
		int taken;
		bit calm;
		taken = 0;
		calm = 1'b0;
		while (!arst_n)
			@(posedge clk);
		m_axis_tready <= 1'b1;
		forever begin
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			taken++;
			if (taken % 16 == 0)
				calm = ($urandom_range(0, 2) == 0);
			stall = calm ? 0 : $urandom_range(0, 11);
			if (taken == 25 || taken == 250)
				stall = HOLD_CYC;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	// compare each result transaction with the oldest expected one
	always @(posedge clk) begin : result_check
		fisher_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (fisher_due.size() == 0) begin
				$display("%0t: result with none expected, m00 %h overflow %b", $time,
					m_axis_tdata[ACC_W-1:0], m_axis_tuser);
				fail_count++;
			end else begin
				want = fisher_due.pop_front();
				for (int k = 0; k < NUM_ACC; k++) begin
					if (m_axis_tdata[k*ACC_W +: ACC_W] !== want.entry[k]) begin
						$display("%0t: %s expected %h, got %h", $time, entry_name[k],
							want.entry[k], m_axis_tdata[k*ACC_W +: ACC_W]);
						fail_count++;
					end
				end
				if (m_axis_tuser !== want.ovf) begin
					$display("%0t: overflow expected %b, got %b", $time, want.ovf,
						m_axis_tuser);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
			IDLE_LIMIT, fisher_due.size());
		$display("emax_fisher_info_accumulator_top_tb NOT OK");
		$finish;
	end

	initial begin : stimulus
		logic [CFG_W-1:0] sl;
		logic [CFG_W-1:0] hp;
		int               set_len;
		int               phase_pts;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, starting from the reset settings of 1.0 and 1.0
		row_typed(24'h000000, 17'h10000, 64'h1_0000_0000, '0, '0, '0, '0, '0, 1'b0);
		row_typed(24'h010000, 17'h10000, 64'h1_0000_0000, 64'h8000_0000,
			64'hFFFF_FFFF_C000_0000, 64'h4000_0000, 64'hFFFF_FFFF_E000_0000,
			64'h1000_0000, 1'b0);
		row_typed(24'hFFFFFF, 17'h00000, '0, '0, '0, '0, '0, '0, 1'b0);
		row_point(24'hFFFFFF, 17'h1FFFF, 1'b0);
		row_point(24'hFFFFFF, 17'h10000, 1'b1);
		row_point(24'h123456, 17'h0AAAA, 1'b0);
		row_point(24'h800000, 17'h15555, 1'b0);
		row_point(24'h000001, 17'h00001, 1'b1);
		// steepest positive slope, tiny half point: slope term clamps
		row_cfg(REG_SLOPE, 24'h7FFFFF);
		row_cfg(REG_HALF, 24'h000001);
		row_typed(24'h000001, 17'h00000, '0, '0, '0, '0, '0, '0, 1'b1);
		row_point(24'h000001, 17'h1FFFF, 1'b0);
		row_point(24'h000001, 17'h1FFFF, 1'b1);
		// most negative slope clamps the other way
		row_cfg(REG_SLOPE, 24'h800000);
		row_point(24'h000001, 17'h1FFFF, 1'b1);
		row_point(24'hFFFFFF, 17'h10000, 1'b1);
		row_cfg(REG_HALF, 24'hFFFFFF);
		row_point(24'hFFFFFF, 17'h10000, 1'b1);
		row_typed(24'h000000, 17'h10000, 64'h1_0000_0000, '0, '0, '0, '0, '0, 1'b0);
		// zero half point with zero dose: divisor is zero
		row_cfg(REG_HALF, 24'h000000);
		row_typed(24'h000000, 17'h10000, 64'h1_0000_0000, '0, '0, '0, '0, '0, 1'b0);
		row_point(24'h000100, 17'h10000, 1'b1);
		row_cfg(REG_SLOPE, 24'h000000);
		row_point(24'h5A5A5A, 17'h0A5A5, 1'b1);
		row_cfg(REG_SLOPE, 24'hFFFFFF);
		row_cfg(REG_HALF, 24'h008000);
		row_point(24'h00FFFF, 17'h1FFFF, 1'b1);

		foreach (stim_rows[i]) begin
			send_calm = ($urandom_range(0, 3) == 0);
			if (stim_rows[i].is_cfg) begin
				settle_idle();
				write_setting(stim_rows[i].sel, stim_rows[i].value);
			end else begin
				offer_point(stim_rows[i].value, stim_rows[i].wt, stim_rows[i].closes,
					stim_rows[i].typed, stim_rows[i].want);
			end
		end

		// random sets under corner and random register settings
		for (int phase = 0; phase < PHASES; phase++) begin
			settle_idle();
			if (phase < 4) begin
				sl = slope_corner[phase];
				hp = half_corner[phase];
			end else begin
				sl = CFG_W'($urandom);
				if ($urandom_range(0, 1))
					sl = CFG_W'($signed(sl) >>> $urandom_range(0, 16));
				hp = CFG_W'($urandom) >> $urandom_range(0, 20);
			end
			write_setting(REG_SLOPE, sl);
			write_setting(REG_HALF, hp);
			phase_pts = 0;
			while (phase_pts < PHASE_PTS) begin
				send_calm = ($urandom_range(0, 5) == 0);
				set_len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) :
					$urandom_range(1, 6);
				for (int j = 0; j < set_len; j++) begin
					offer_point(pick_dose(), pick_weight(), j == set_len - 1, 1'b0, '0);
					phase_pts++;
				end
			end
		end
		settle_idle();

		$display("ran %0d design points in %0d sets (%0d with overflow) over %0d register writes",
			point_count, set_count, sat_sets, setting_count);
		$display("mismatches found: %0d", fail_count);
		if (fail_count == 0)
			$display("emax_fisher_info_accumulator_top_tb OK");
		else
			$display("emax_fisher_info_accumulator_top_tb NOT OK");
		$finish;
	end

endmodule
